### design/ssoe_pkg.sv
// ----------------------------------------------------------------------------
// ssoe_pkg - shared constants, types and helpers of the sorted set engine
// Element storage format, list sizing, command and mode codes, and the
// request bundle that drives one list memory.
// ----------------------------------------------------------------------------
`default_nettype none

package ssoe_pkg;

	localparam int unsigned MAX_ELEMENTS = 16;
	localparam int unsigned VALUE_WIDTH  = 32;

	localparam int unsigned ADDR_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int unsigned CNT_W  = $clog2(MAX_ELEMENTS + 1);

	typedef logic [ADDR_W-1:0]      addr_t;
	typedef logic [CNT_W-1:0]       cnt_t;
	typedef logic [VALUE_WIDTH-1:0] elem_t;

	localparam logic [1:0] CMD_LOAD_A = 2'd0;
	localparam logic [1:0] CMD_LOAD_B = 2'd1;
	localparam logic [1:0] CMD_START  = 2'd2;

	localparam logic [1:0] MODE_UNION     = 2'd0;
	localparam logic [1:0] MODE_INTERSECT = 2'd1;
	localparam logic [1:0] MODE_A_MINUS_B = 2'd2;
	localparam logic [1:0] MODE_B_MINUS_A = 2'd3;

	typedef struct packed {
		logic  we;
		addr_t waddr;
		elem_t wdata;
		logic  re;
		addr_t raddr;
	} mem_req_t;

	// Keep the low element bits of a 32-bit beat; zero-fill when elements are wider.
	function automatic elem_t to_elem(input logic [31:0] v);
		logic [63:0] t;
		t = {32'd0, v};
		return t[VALUE_WIDTH-1:0];
	endfunction

	// Sign-extend a stored element and take its low 32 bits.
	function automatic logic [31:0] to_result(input elem_t v);
		logic [63:0] t;
		t = 64'(signed'(v));
		return t[31:0];
	endfunction

endpackage

`default_nettype wire

### design/sorted_set_operation_engine.sv
// ----------------------------------------------------------------------------
// sorted_set_operation_engine - union / intersection / differences of lists
// Keeps lists A and B sorted in two memories by insertion on every load,
// then walks both in merge order on start and emits the selected set result.
//
//   channel | direction | beat contents
//   --------+-----------+------------------------------------------------------
//   in      | sink      | command, element_value
//   out     | source    | result_value, last_item, empty_result, overflow_seen
//   cfg     | sink      | operation_mode (always ready)
//
// Load into an empty list writes the element directly. Otherwise each stored
// element greater than the new one is shifted up, from the end down, and the
// new element is written into the freed place: one read and one write of the
// list memory per shifted entry. A load into a full list is dropped.
// Start: one merge step per consumed head pair or head, at most count_a +
// count_b steps, each a head read then a compare; a closing step ends the run.
// A stalled out channel holds the merge walk; loads proceed while the last
// result beat waits. Reset clears counts, mode and flags; no memory clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_set_operation_engine (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  wire         [1:0]  command,
	input  wire  signed [31:0] element_value,
	output logic               out_valid,
	input  wire                out_ready,
	output logic signed [31:0] result_value,
	output logic               last_item,
	output logic               empty_result,
	output logic               overflow_seen,
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire         [1:0]  operation_mode
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS,
		ST_INS_LAST,
		ST_MRD,
		ST_MCMP
	} state_t;

	state_t             state_q;
	logic [1:0]         mode_q;
	ssoe_pkg::cnt_t     cnt_a_q, cnt_b_q, ia_q, ib_q;
	logic               ovf_q;
	logic               sel_q;
	ssoe_pkg::addr_t    k_q;
	ssoe_pkg::elem_t    val_q;
	logic               pend_valid_q;
	ssoe_pkg::elem_t    pend_q;
	logic               out_valid_q, out_last_q, out_empty_q, out_ovf_q;
	logic [31:0]        out_value_q;

	ssoe_pkg::mem_req_t mem_a, mem_b, ins_req;
	ssoe_pkg::elem_t    rd_a, rd_b, rd_sel, load_val, emit_val;
	ssoe_pkg::cnt_t     cur_cnt, cur_cnt_m1;
	logic               in_acc, is_load, room, out_free, ins_gt, tgt_b;
	logic               have_a, have_b, en_eq, en_a, en_b;
	logic               done, emit, inc_a, inc_b, stall, out_push;

	ssoe_ram u_ram_a (.clk(clk), .req(mem_a), .rdata(rd_a));
	ssoe_ram u_ram_b (.clk(clk), .req(mem_b), .rdata(rd_b));

	assign in_ready   = (state_q == ST_IDLE);
	assign cfg_ready  = 1'b1;
	assign in_acc     = in_valid && in_ready;
	assign is_load    = (command == ssoe_pkg::CMD_LOAD_A) || (command == ssoe_pkg::CMD_LOAD_B);
	assign out_free   = !out_valid_q || out_ready;
	assign load_val   = ssoe_pkg::to_elem(element_value);
	assign cur_cnt    = (command == ssoe_pkg::CMD_LOAD_B) ? cnt_b_q : cnt_a_q;
	assign cur_cnt_m1 = cur_cnt - ssoe_pkg::cnt_t'(1);
	assign room       = cur_cnt < ssoe_pkg::cnt_t'(ssoe_pkg::MAX_ELEMENTS);
	assign rd_sel     = sel_q ? rd_b : rd_a;
	assign ins_gt     = $signed(rd_sel) > $signed(val_q);

	assign en_eq = (mode_q == ssoe_pkg::MODE_UNION) || (mode_q == ssoe_pkg::MODE_INTERSECT);
	assign en_a  = (mode_q == ssoe_pkg::MODE_UNION) || (mode_q == ssoe_pkg::MODE_A_MINUS_B);
	assign en_b  = (mode_q == ssoe_pkg::MODE_UNION) || (mode_q == ssoe_pkg::MODE_B_MINUS_A);

	assign have_a = ia_q < cnt_a_q;
	assign have_b = ib_q < cnt_b_q;

	// merge step decision on the two registered heads
	always_comb begin
		done     = 1'b0;
		emit     = 1'b0;
		inc_a    = 1'b0;
		inc_b    = 1'b0;
		emit_val = rd_a;
		if (have_a && have_b) begin
			if (rd_a == rd_b) begin
				emit  = en_eq;
				inc_a = 1'b1;
				inc_b = 1'b1;
			end else if ($signed(rd_a) < $signed(rd_b)) begin
				emit  = en_a;
				inc_a = 1'b1;
			end else begin
				emit     = en_b;
				emit_val = rd_b;
				inc_b    = 1'b1;
			end
		end else if (have_a) begin
			emit  = en_a;
			inc_a = en_a;
			done  = !en_a;
		end else if (have_b) begin
			emit     = en_b;
			emit_val = rd_b;
			inc_b    = en_b;
			done     = !en_b;
		end else begin
			done = 1'b1;
		end
		stall = done ? !out_free : (emit && pend_valid_q && !out_free);
	end

	assign out_push = (state_q == ST_MCMP) && !stall && (done || (emit && pend_valid_q));

	// memory requests
	always_comb begin
		ins_req = '0;
		tgt_b   = sel_q;
		mem_a   = '0;
		mem_b   = '0;
		unique case (state_q)
			ST_IDLE: begin
				tgt_b = (command == ssoe_pkg::CMD_LOAD_B);
				if (in_acc && is_load && room) begin
					if (cur_cnt == '0) begin
						ins_req.we    = 1'b1;
						ins_req.waddr = '0;
						ins_req.wdata = load_val;
					end else begin
						ins_req.re    = 1'b1;
						ins_req.raddr = cur_cnt_m1[ssoe_pkg::ADDR_W-1:0];
					end
				end
			end
			ST_INS: begin
				ins_req.we    = 1'b1;
				ins_req.waddr = k_q + ssoe_pkg::addr_t'(1);
				if (ins_gt) begin
					ins_req.wdata = rd_sel;
					if (k_q != '0) begin
						ins_req.re    = 1'b1;
						ins_req.raddr = k_q - ssoe_pkg::addr_t'(1);
					end
				end else begin
					ins_req.wdata = val_q;
				end
			end
			ST_INS_LAST: begin
				ins_req.we    = 1'b1;
				ins_req.waddr = '0;
				ins_req.wdata = val_q;
			end
			ST_MRD, ST_MCMP: begin
				ins_req = '0;
			end
			default: begin
				ins_req = '0;
			end
		endcase
		if (tgt_b) begin
			mem_b = ins_req;
		end else begin
			mem_a = ins_req;
		end
		if (state_q == ST_MRD) begin
			mem_a.re    = 1'b1;
			mem_a.raddr = ia_q[ssoe_pkg::ADDR_W-1:0];
			mem_b.re    = 1'b1;
			mem_b.raddr = ib_q[ssoe_pkg::ADDR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			mode_q       <= ssoe_pkg::MODE_UNION;
			cnt_a_q      <= '0;
			cnt_b_q      <= '0;
			ia_q         <= '0;
			ib_q         <= '0;
			ovf_q        <= 1'b0;
			sel_q        <= 1'b0;
			k_q          <= '0;
			val_q        <= '0;
			pend_valid_q <= 1'b0;
			pend_q       <= '0;
			out_valid_q  <= 1'b0;
			out_value_q  <= '0;
			out_last_q   <= 1'b0;
			out_empty_q  <= 1'b0;
			out_ovf_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mode_q <= operation_mode;
			end
			if (out_push) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (command) inside
							ssoe_pkg::CMD_LOAD_A, ssoe_pkg::CMD_LOAD_B: begin
								if (room) begin
									if (command == ssoe_pkg::CMD_LOAD_B) begin
										cnt_b_q <= cnt_b_q + ssoe_pkg::cnt_t'(1);
									end else begin
										cnt_a_q <= cnt_a_q + ssoe_pkg::cnt_t'(1);
									end
									sel_q <= (command == ssoe_pkg::CMD_LOAD_B);
									val_q <= load_val;
									k_q   <= cur_cnt_m1[ssoe_pkg::ADDR_W-1:0];
									if (cur_cnt != '0) begin
										state_q <= ST_INS;
									end
								end else begin
									ovf_q <= 1'b1;
								end
							end
							ssoe_pkg::CMD_START: begin
								ia_q         <= '0;
								ib_q         <= '0;
								pend_valid_q <= 1'b0;
								state_q      <= ST_MRD;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_INS: begin
					if (ins_gt) begin
						if (k_q == '0) begin
							state_q <= ST_INS_LAST;
						end else begin
							k_q <= k_q - ssoe_pkg::addr_t'(1);
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_INS_LAST: begin
					state_q <= ST_IDLE;
				end
				ST_MRD: begin
					state_q <= ST_MCMP;
				end
				ST_MCMP: begin
					if (!stall) begin
						if (done) begin
							out_value_q  <= pend_valid_q ? ssoe_pkg::to_result(pend_q) : 32'd0;
							out_last_q   <= 1'b1;
							out_empty_q  <= !pend_valid_q;
							out_ovf_q    <= ovf_q;
							ovf_q        <= 1'b0;
							pend_valid_q <= 1'b0;
							state_q      <= ST_IDLE;
						end else begin
							if (emit) begin
								if (pend_valid_q) begin
									out_value_q <= ssoe_pkg::to_result(pend_q);
									out_last_q  <= 1'b0;
									out_empty_q <= 1'b0;
									out_ovf_q   <= ovf_q;
								end
								pend_q       <= emit_val;
								pend_valid_q <= 1'b1;
							end
							ia_q    <= ia_q + ssoe_pkg::cnt_t'(inc_a);
							ib_q    <= ib_q + ssoe_pkg::cnt_t'(inc_b);
							state_q <= ST_MRD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign result_value  = out_value_q;
	assign last_item     = out_last_q;
	assign empty_result  = out_empty_q;
	assign overflow_seen = out_ovf_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_a_q <= ssoe_pkg::cnt_t'(ssoe_pkg::MAX_ELEMENTS)) &&
		(cnt_b_q <= ssoe_pkg::cnt_t'(ssoe_pkg::MAX_ELEMENTS)))
		else $error("list count beyond capacity");

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_a.we |-> ssoe_pkg::cnt_t'(mem_a.waddr) <= cnt_a_q) and
		(mem_b.we |-> ssoe_pkg::cnt_t'(mem_b.waddr) <= cnt_b_q))
		else $error("insertion write beyond list fill");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MCMP) |-> (ia_q <= cnt_a_q) && (ib_q <= cnt_b_q))
		else $error("merge index past list end");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_empty_q) |-> out_last_q)
		else $error("empty result beat not marked last");

	a_ovf_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MCMP && !stall && done) |=> !ovf_q)
		else $error("overflow flag survived start");

endmodule

`default_nettype wire

### design/ssoe_ram.sv
// ----------------------------------------------------------------------------
// ssoe_ram - one list memory
// Single write port, single read port with enable; read data registered,
// held while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module ssoe_ram (
	input  wire                     clk,
	input  wire ssoe_pkg::mem_req_t req,
	output ssoe_pkg::elem_t         rdata
);

	ssoe_pkg::elem_t mem [ssoe_pkg::MAX_ELEMENTS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

`default_nettype wire
